// ===== sv/mac_presence_table_with_aging_defines.svh =====
// Assertion macros for the MAC presence table checker
`ifndef MAC_PRESENCE_TABLE_WITH_AGING_DEFINES_SVH
`define MAC_PRESENCE_TABLE_WITH_AGING_DEFINES_SVH

// Implication checked on every clock edge outside reset
`define MPT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset
`define MPT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/mpt_pkg.sv =====
// Shared types and constants of the MAC presence table
package mpt_pkg;

    localparam logic [31:0] AGE_LIMIT_RESET = 32'd600000;
    localparam logic [15:0] U16_MAX = 16'hFFFF;

    typedef struct packed {
        logic [47:0] mac_address;
        logic [31:0] now_ms;
    } in_beat_t;

    typedef struct packed {
        logic        hit;
        logic [15:0] entry_id;
        logic [15:0] message_count;
        logic [15:0] mean_interval_ms;
        logic [6:0]  aged_out;
        logic        table_full;
    } out_beat_t;

    typedef struct packed {
        logic [47:0] address;
        logic [31:0] last_seen;
        logic [15:0] count;
        logic [15:0] interval;
        logic [15:0] ident;
    } slot_t;

    typedef struct packed {
        logic        start;
        logic [47:0] dividend;
        logic [16:0] divisor;
    } div_req_t;

endpackage

// ===== sv/mpt_divider.sv =====
// Restoring divider, one quotient bit per cycle
module mpt_divider
(
    input  logic                clk,
    input  logic                rst_n,
    input  mpt_pkg::div_req_t   req,
    output logic                done,
    output logic [47:0]         quotient
);

    logic [47:0] quot_reg, quot_next;
    logic [16:0] div_reg;
    logic [17:0] rem_reg, rem_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [17:0] trial;

    always_comb
    begin
        trial      = {rem_reg[16:0], quot_reg[47]} - {1'b0, div_reg};
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (req.start)
        begin
            quot_next = req.dividend;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[17])
            begin
                rem_next  = trial;
                quot_next = {quot_reg[46:0], 1'b1};
            end
            else
            begin
                rem_next  = {rem_reg[16:0], quot_reg[47]};
                quot_next = {quot_reg[46:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd47)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        if (req.start)
        begin
            div_reg <= req.divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

// ===== sv/mac_presence_table_with_aging.sv =====
// Top level of the MAC presence table with aging
// A frame that hits passes through an aging sweep, a lookup sweep, a divider load, a wait for
// the divider and a write-back before its result strobe; a miss or a dropped frame skips the
// divider. An aging sweep reads every slot through the registered-read slot memory and a
// lookup sweep reads every slot again. A hit then loads the 48-step serial divider (ST_PREP)
// and waits for the running mean (ST_DIV). The write-back state (ST_WRITE) follows. busy is
// high from the edge after start until the result strobe and is low during the strobe cycle,
// so the next start can be taken at the edge that ends it. The result is shown for one cycle
// with done and must be taken, since the receiver cannot stall it.
module mac_presence_table_with_aging
#(
    parameter int TABLE_ENTRIES = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  mpt_pkg::in_beat_t   in_beat,
    output logic                done,
    output mpt_pkg::out_beat_t  out_beat,
    input  logic                cfg_we,
    input  logic [31:0]         cfg_data
);

    localparam int IW = (TABLE_ENTRIES > 2) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = IW + 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_AGE   = 3'd1;
    localparam logic [2:0] ST_LOOK  = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_WRITE = 3'd4;
    localparam logic [2:0] ST_PREP  = 3'd5;

    mpt_pkg::slot_t mem [TABLE_ENTRIES];
    mpt_pkg::slot_t rd_data;
    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;

    logic [2:0]  state_reg, state_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic        rd_pend_reg, rd_pend_next;
    logic [IW-1:0] rd_idx_reg, rd_idx_next;
    logic [31:0] age_reg;
    logic [47:0] mac_reg;
    logic [31:0] now_reg;
    logic [6:0]  aged_reg, aged_next;
    logic        match_reg, match_next;
    logic [IW-1:0] match_idx_reg, match_idx_next;
    mpt_pkg::slot_t match_slot_reg, match_slot_next;
    logic        free_reg, free_next;
    logic [IW-1:0] free_idx_reg, free_idx_next;
    logic [15:0] ident_reg, ident_next;
    logic        done_reg, done_next;
    mpt_pkg::out_beat_t res_reg, res_next;

    logic        wr_en;
    logic [IW-1:0] wr_idx;
    mpt_pkg::slot_t wr_data;
    logic [IW-1:0] rd_addr;

    mpt_pkg::div_req_t div_req;
    logic        div_done;
    logic [47:0] div_q;
    logic [31:0] gap;
    logic [31:0] prod;
    logic [15:0] mean_sat, cnt_new;

    assign gap      = now_reg - match_slot_reg.last_seen;
    assign prod     = 32'(match_slot_reg.count) * 32'(match_slot_reg.interval);
    assign mean_sat = (div_q[47:16] != '0) ? mpt_pkg::U16_MAX : div_q[15:0];
    assign cnt_new  = (match_slot_reg.count == mpt_pkg::U16_MAX)
                      ? mpt_pkg::U16_MAX : match_slot_reg.count + 16'd1;

    mpt_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_q)
    );

    assign rd_addr = idx_reg[IW-1:0];

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        rd_pend_next    = 1'b0;
        rd_idx_next     = rd_addr;
        valid_next      = valid_reg;
        aged_next       = aged_reg;
        match_next      = match_reg;
        match_idx_next  = match_idx_reg;
        match_slot_next = match_slot_reg;
        free_next       = free_reg;
        free_idx_next   = free_idx_reg;
        ident_next      = ident_reg;
        done_next       = 1'b0;
        res_next        = res_reg;
        wr_en           = 1'b0;
        wr_idx          = match_idx_reg;
        wr_data         = match_slot_reg;
        div_req.start    = 1'b0;
        div_req.dividend = {16'd0, gap} + {16'd0, prod};
        div_req.divisor  = 17'(match_slot_reg.count) + 17'd1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_AGE;
                    idx_next   = '0;
                    aged_next  = '0;
                    match_next = 1'b0;
                    free_next  = 1'b0;
                end
            end
            ST_AGE:
            begin
                if (rd_pend_reg && valid_reg[rd_idx_reg]
                    && (now_reg - rd_data.last_seen) > age_reg)
                begin
                    valid_next[rd_idx_reg] = 1'b0;
                    aged_next = aged_reg + 7'd1;
                end
                if (idx_reg == CW'(TABLE_ENTRIES))
                begin
                    state_next = ST_LOOK;
                    idx_next   = '0;
                end
                else
                begin
                    rd_pend_next = 1'b1;
                    idx_next     = idx_reg + 1'b1;
                end
            end
            ST_LOOK:
            begin
                if (rd_pend_reg)
                begin
                    if (valid_reg[rd_idx_reg])
                    begin
                        if (!match_reg && rd_data.address == mac_reg)
                        begin
                            match_next      = 1'b1;
                            match_idx_next  = rd_idx_reg;
                            match_slot_next = rd_data;
                        end
                    end
                    else if (!free_reg)
                    begin
                        free_next     = 1'b1;
                        free_idx_next = rd_idx_reg;
                    end
                end
                if (idx_reg == CW'(TABLE_ENTRIES))
                begin
                    state_next = match_next ? ST_PREP : ST_WRITE;
                end
                else
                begin
                    rd_pend_next = 1'b1;
                    idx_next     = idx_reg + 1'b1;
                end
            end
            ST_PREP:
            begin
                div_req.start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                state_next        = ST_IDLE;
                done_next         = 1'b1;
                res_next          = '0;
                res_next.aged_out = aged_reg;
                if (match_reg)
                begin
                    wr_en            = 1'b1;
                    wr_data.count    = cnt_new;
                    wr_data.interval = mean_sat;
                    wr_data.last_seen = now_reg;
                    res_next.hit              = 1'b1;
                    res_next.entry_id         = match_slot_reg.ident;
                    res_next.message_count    = cnt_new;
                    res_next.mean_interval_ms = mean_sat;
                end
                else if (free_reg)
                begin
                    wr_en             = 1'b1;
                    wr_idx            = free_idx_reg;
                    wr_data.address   = mac_reg;
                    wr_data.last_seen = now_reg;
                    wr_data.count     = '0;
                    wr_data.interval  = '0;
                    wr_data.ident     = ident_reg;
                    valid_next[free_idx_reg] = 1'b1;
                    ident_next        = ident_reg + 16'd1;
                    res_next.entry_id = ident_reg;
                end
                else
                begin
                    res_next.table_full = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            rd_pend_reg <= 1'b0;
            valid_reg   <= '0;
            ident_reg   <= '0;
            done_reg    <= 1'b0;
            age_reg     <= mpt_pkg::AGE_LIMIT_RESET;
            match_reg   <= 1'b0;
            free_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            rd_pend_reg <= rd_pend_next;
            valid_reg   <= valid_next;
            ident_reg   <= ident_next;
            done_reg    <= done_next;
            match_reg   <= match_next;
            free_reg    <= free_next;
            if (cfg_we)
            begin
                age_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg     <= rd_idx_next;
        aged_reg       <= aged_next;
        match_idx_reg  <= match_idx_next;
        match_slot_reg <= match_slot_next;
        free_idx_reg   <= free_idx_next;
        res_reg        <= res_next;
        if (start && state_reg == ST_IDLE)
        begin
            mac_reg <= in_beat.mac_address;
            now_reg <= in_beat.now_ms;
        end
    end

    assign busy     = state_reg != ST_IDLE;
    assign done     = done_reg;
    assign out_beat = res_reg;

endmodule

// ===== sv/mpt_checker.sv =====
// Port-level checker for the MAC presence table, bound to the top level
`include "mac_presence_table_with_aging_defines.svh"

module mpt_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input mpt_pkg::out_beat_t out_beat
);

    `MPT_ASSERT_NXT(a_start_busy, clk, rst_n, start && !busy, busy)
    `MPT_ASSERT_IMP(a_done_idle, clk, rst_n, done, !busy)
    `MPT_ASSERT_NXT(a_done_pulse, clk, rst_n, done, !done)
    `MPT_ASSERT_IMP(a_hit_full, clk, rst_n, done, !(out_beat.hit && out_beat.table_full))
    `MPT_ASSERT_IMP(a_full_zero, clk, rst_n, done && out_beat.table_full,
        out_beat.entry_id == 16'd0 && out_beat.message_count == 16'd0)

endmodule

bind mac_presence_table_with_aging mpt_checker u_mpt_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .done     (done),
    .out_beat (out_beat)
);

// ===== dv/tb.sv =====
// Testbench for the MAC presence table: scoreboard class with its own table model
class presence_scoreboard;
    logic [31:0] age_limit;
    bit          valid_q[64];
    logic [47:0] addr_q[64];
    logic [31:0] seen_q[64];
    logic [15:0] count_q[64];
    logic [15:0] mean_q[64];
    logic [15:0] ident_q[64];
    logic [15:0] next_id;
    mpt_pkg::out_beat_t pending_q[$];
    int          errors;

    function new();
        age_limit = mpt_pkg::AGE_LIMIT_RESET;
        next_id = 0;
        errors = 0;
        foreach (valid_q[i]) valid_q[i] = 0;
    endfunction

    function void note_frame(mpt_pkg::in_beat_t b);
        mpt_pkg::out_beat_t r;
        int hit_slot;
        int free_slot;
        logic [63:0] n;
        logic [63:0] gap;
        logic [63:0] avg;
        r = '0;
        hit_slot = -1;
        free_slot = -1;
        for (int i = 0; i < 64; i++)
        begin
            if (valid_q[i] && (b.now_ms - seen_q[i]) > age_limit)
            begin
                valid_q[i] = 0;
                r.aged_out = r.aged_out + 7'd1;
            end
        end
        for (int i = 0; i < 64; i++)
        begin
            if (valid_q[i])
            begin
                if (hit_slot < 0 && addr_q[i] == b.mac_address) hit_slot = i;
            end
            else if (free_slot < 0)
                free_slot = i;
        end
        if (hit_slot >= 0)
        begin
            n = count_q[hit_slot];
            gap = {32'd0, b.now_ms - seen_q[hit_slot]};
            avg = (gap + n * mean_q[hit_slot]) / (n + 64'd1);
            if (avg > 64'hFFFF) avg = 64'hFFFF;
            if (n < 64'hFFFF) n = n + 64'd1;
            count_q[hit_slot] = n[15:0];
            mean_q[hit_slot] = avg[15:0];
            seen_q[hit_slot] = b.now_ms;
            r.hit = 1;
            r.entry_id = ident_q[hit_slot];
            r.message_count = n[15:0];
            r.mean_interval_ms = avg[15:0];
        end
        else if (free_slot >= 0)
        begin
            valid_q[free_slot] = 1;
            addr_q[free_slot] = b.mac_address;
            seen_q[free_slot] = b.now_ms;
            count_q[free_slot] = 0;
            mean_q[free_slot] = 0;
            ident_q[free_slot] = next_id;
            r.entry_id = next_id;
            next_id = next_id + 16'd1;
        end
        else
            r.table_full = 1;
        pending_q = {pending_q, r};
    endfunction

    function void check_result(mpt_pkg::out_beat_t a);
        mpt_pkg::out_beat_t e;
        if (pending_q.size() == 0)
        begin
            $error("unexpected result beat");
            errors++;
            return;
        end
        e = pending_q.pop_front();
        if (a.hit !== e.hit)
        begin
            $error("hit: expected %0d actual %0d", e.hit, a.hit);
            errors++;
        end
        if (a.entry_id !== e.entry_id)
        begin
            $error("entry_id: expected %0d actual %0d", e.entry_id, a.entry_id);
            errors++;
        end
        if (a.message_count !== e.message_count)
        begin
            $error("message_count: expected %0d actual %0d", e.message_count,
                a.message_count);
            errors++;
        end
        if (a.mean_interval_ms !== e.mean_interval_ms)
        begin
            $error("mean_interval_ms: expected %0d actual %0d", e.mean_interval_ms,
                a.mean_interval_ms);
            errors++;
        end
        if (a.aged_out !== e.aged_out)
        begin
            $error("aged_out: expected %0d actual %0d", e.aged_out, a.aged_out);
            errors++;
        end
        if (a.table_full !== e.table_full)
        begin
            $error("table_full: expected %0d actual %0d", e.table_full, a.table_full);
            errors++;
        end
    endfunction
endclass

module tb;
    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    mpt_pkg::in_beat_t  in_beat;
    logic      done;
    mpt_pkg::out_beat_t out_beat;
    logic      cfg_we;
    logic [31:0] cfg_data;

    presence_scoreboard board;
    int          idle_pct;
    logic [31:0] clock_ms;
    logic [47:0] known_macs[$];

    mac_presence_table_with_aging dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .in_beat(in_beat),
        .done(done),
        .out_beat(out_beat),
        .cfg_we(cfg_we),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #400000000;
        $display("Some tests failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && done) board.check_result(out_beat);
    end

    task automatic send_frame(input logic [47:0] mac, input logic [31:0] now);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 0;
            @(negedge clk);
            while ($urandom_range(99) < idle_pct) @(negedge clk);
        end
        start <= 1;
        in_beat <= {mac, now};
        @(posedge clk);
        while (busy) @(posedge clk);
        board.note_frame({mac, now});
        @(negedge clk);
    endtask

    task automatic drain();
        start <= 0;
        while (board.pending_q.size() != 0) @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    task automatic set_age_limit(input logic [31:0] v);
        drain();
        cfg_we <= 1;
        cfg_data <= v;
        @(negedge clk);
        cfg_we <= 0;
        board.age_limit = v;
    endtask

    task automatic random_frame(input int span);
        logic [47:0] mac;
        if (known_macs.size() != 0 && $urandom_range(99) < 70)
            mac = known_macs[$urandom_range(known_macs.size() - 1)];
        else
        begin
            mac = 48'({$urandom, $urandom});
            if ($urandom_range(3) == 0) mac = {44'd0, 4'($urandom)};
            if (known_macs.size() < 90) known_macs = {known_macs, mac};
        end
        case ($urandom_range(9))
            0: clock_ms = $urandom;
            1: clock_ms = clock_ms + $urandom_range(300000);
            default: clock_ms = clock_ms + $urandom_range(span);
        endcase
        send_frame(mac, clock_ms);
    endtask

    initial
    begin
        board = new();
        rst_n = 0;
        start = 0;
        in_beat = '0;
        cfg_we = 0;
        cfg_data = '0;
        idle_pct = 29;
        clock_ms = 0;
        repeat (4) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        send_frame(48'd0, 32'd0);
        send_frame(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        send_frame(48'd0, 32'd5);
        send_frame(48'd0, 32'd200005);
        send_frame(48'hFFFF_FFFF_FFFF, 32'd100);
        send_frame(48'd0, 32'd1000000);
        set_age_limit(32'hFFFF_FFFF);
        for (int i = 0; i < 66; i++) send_frame(48'h0A0000 + i, 32'd1000000 + i);
        send_frame(48'h0A0000, 32'd1);
        set_age_limit(32'd0);
        send_frame(48'h123456789ABC, 32'd1000100);
        send_frame(48'h123456789ABC, 32'd1000100);
        send_frame(48'h123456789ABC, 32'd1000101);
        set_age_limit(32'd50);
        drain();
        for (int i = 0; i < 100; i++)
            send_frame(48'h5A5A5A5A5A5A, 32'd2000000 + i * 40);
        set_age_limit(mpt_pkg::AGE_LIMIT_RESET);

        clock_ms = 32'd5000000;
        for (int i = 0; i < 1000; i++)
        begin
            if (i == 333) idle_pct = 66;
            if (i == 666) idle_pct = 0;
            if (i == 250) set_age_limit(32'd20000);
            if (i == 500)
            begin
                drain();
                set_age_limit(32'd400);
            end
            if (i == 850) set_age_limit(mpt_pkg::AGE_LIMIT_RESET);
            random_frame(i >= 500 && i < 850 ? 200 : 40000);
        end
        drain();
        if (board.errors == 0 && board.pending_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
